// ===== hdl/ppp_pkg.sv =====
// Shared types, constants and the arctangent lookup function for the perspective point projector.
package ppp_pkg;

  localparam int COORD_FRAC_BITS = 12;
  localparam int COORD_W         = 16;
  localparam int OUT_W           = 16;
  localparam int OUT_FRAC_BITS   = 4;

  // config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ANGLE_W    = 16;
  localparam int DIST_W     = 15;
  localparam int PIX_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd5;

  localparam logic [DIST_W-1:0] DISTANCE_RST = DIST_W'(3 << COORD_FRAC_BITS);
  localparam logic [PIX_W-1:0]  SCALE_RST    = 12'd250;
  localparam logic [PIX_W-1:0]  CENTER_X_RST = 12'd400;
  localparam logic [PIX_W-1:0]  CENTER_Y_RST = 12'd300;

  // cordic
  localparam int CORDIC_STEPS = 14;
  localparam int STEP_W       = 4;
  localparam int XY_W         = 19;
  localparam int Z_W          = 17;
  localparam int TRIG_W       = 16;
  localparam int TRIG_ONE     = 16384;
  localparam int CORDIC_GAIN  = 39797;

  // datapath widths
  localparam int PROD1_W = 32;
  localparam int ROT_W   = 20;
  localparam int PROD2_W = 36;
  localparam int DEPTH_W = 21;
  localparam int DIV_W   = 20;
  localparam int SPROD_W = 33;
  localparam int NUM_W   = 37;
  localparam int QBITS   = 18;
  localparam int TOT_W   = 20;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_x;
    logic [ANGLE_W-1:0] angle_y;
    logic [DIST_W-1:0]  distance;
    logic [PIX_W-1:0]   scale;
    logic [PIX_W-1:0]   center_x;
    logic [PIX_W-1:0]   center_y;
  } cfg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_y;
  } trig_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [2:0] {
    TRIG_LOAD_X,
    TRIG_RUN_X,
    TRIG_LOAD_Y,
    TRIG_RUN_Y,
    TRIG_STORE_Y,
    TRIG_IDLE
  } trig_state_e;

  typedef struct packed {
    logic load;
    logic iterate;
    logic store_x;
    logic store_y;
    logic ready;
  } trig_ctrl_t;

  // arctangent of 2^-i, quarter turn = 16384
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      4'd0:    r = 17'sd8192;
      4'd1:    r = 17'sd4836;
      4'd2:    r = 17'sd2555;
      4'd3:    r = 17'sd1297;
      4'd4:    r = 17'sd651;
      4'd5:    r = 17'sd326;
      4'd6:    r = 17'sd163;
      4'd7:    r = 17'sd81;
      4'd8:    r = 17'sd41;
      4'd9:    r = 17'sd20;
      4'd10:   r = 17'sd10;
      4'd11:   r = 17'sd5;
      4'd12:   r = 17'sd3;
      4'd13:   r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ppp_front.sv =====
// Front end: configuration registers, command acceptance and the input stage.
module ppp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ppp_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [ppp_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [ppp_pkg::COORD_W-1:0]  point_z_i,
  input  logic                                cfg_we_i,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ppp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                trig_ready_i,
  input  logic                                queue_full_i,
  output ppp_pkg::cfg_t                       cfg_o,
  output logic                                trig_req_o,
  output logic                                push_o,
  output ppp_pkg::point_t                     point_o
);
  import ppp_pkg::*;

  cfg_t   cfg_q;
  point_t point_q;
  logic   vld_q;
  logic   accept;

  assign busy   = ~trig_ready_i | (vld_q & queue_full_i);
  assign accept = start & ~busy;
  assign push_o = vld_q & ~queue_full_i;

  // an angle change restarts the sine/cosine unit
  assign trig_req_o = cfg_we_i & ((cfg_idx_i == REG_ANGLE_X) | (cfg_idx_i == REG_ANGLE_Y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_x  <= '0;
      cfg_q.angle_y  <= '0;
      cfg_q.distance <= DISTANCE_RST;
      cfg_q.scale    <= SCALE_RST;
      cfg_q.center_x <= CENTER_X_RST;
      cfg_q.center_y <= CENTER_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ANGLE_X:  cfg_q.angle_x  <= cfg_data_i[ANGLE_W-1:0];
        REG_ANGLE_Y:  cfg_q.angle_y  <= cfg_data_i[ANGLE_W-1:0];
        REG_DISTANCE: cfg_q.distance <= cfg_data_i[DIST_W-1:0];
        REG_SCALE:    cfg_q.scale    <= cfg_data_i[PIX_W-1:0];
        REG_CENTER_X: cfg_q.center_x <= cfg_data_i[PIX_W-1:0];
        REG_CENTER_Y: cfg_q.center_y <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      point_q.x <= point_x_i;
      point_q.y <= point_y_i;
      point_q.z <= point_z_i;
    end
  end

  assign cfg_o   = cfg_q;
  assign point_o = point_q;

endmodule

// ===== hdl/ppp_trig.sv =====
// Shared iterative CORDIC: sine and cosine of both rotation angles.
module ppp_trig (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppp_pkg::cfg_t  cfg_i,
  input  logic           req_i,
  output ppp_pkg::trig_t trig_o,
  output logic           ready_o
);
  import ppp_pkg::*;

  trig_state_e state_q, state_d;
  trig_ctrl_t  ctrl;

  logic signed [XY_W-1:0] x_q, y_q, dx, dy;
  logic signed [Z_W-1:0]  z_q;
  logic [STEP_W-1:0]      step_q;
  logic [1:0]             quad_q;
  logic [ANGLE_W-1:0]     angle;
  logic                   last_step;
  trig_t                  trig_q;

  // round Q2.16 to Q1.14 and clamp to one
  function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] t;
    t = (XY_W+1)'(v) + (XY_W+1)'(2);
    t = t >>> 2;
    if (t > TRIG_ONE) begin
      t = (XY_W+1)'(TRIG_ONE);
    end else if (t < -TRIG_ONE) begin
      t = -(XY_W+1)'(TRIG_ONE);
    end
    return TRIG_W'(t);
  endfunction

  // returns {cos, sin} after quadrant turn
  function automatic logic [2*TRIG_W-1:0] trig_fold(input logic [1:0] quad,
                                                    input logic signed [XY_W-1:0] xv,
                                                    input logic signed [XY_W-1:0] yv);
    logic signed [TRIG_W-1:0] c, s, co, so;
    c = trig_round(xv);
    s = trig_round(yv);
    case (quad)
      2'd1: begin
        co = -s;
        so = c;
      end
      2'd2: begin
        co = -c;
        so = -s;
      end
      2'd3: begin
        co = s;
        so = -c;
      end
      default: begin
        co = c;
        so = s;
      end
    endcase
    return {co, so};
  endfunction

  assign last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      TRIG_LOAD_X:  state_d = TRIG_RUN_X;
      TRIG_RUN_X:   state_d = last_step ? TRIG_LOAD_Y : TRIG_RUN_X;
      TRIG_LOAD_Y:  state_d = TRIG_RUN_Y;
      TRIG_RUN_Y:   state_d = last_step ? TRIG_STORE_Y : TRIG_RUN_Y;
      TRIG_STORE_Y: state_d = TRIG_IDLE;
      TRIG_IDLE:    state_d = TRIG_IDLE;
      default:      state_d = TRIG_LOAD_X;
    endcase
    if (req_i) begin
      state_d = TRIG_LOAD_X;
    end
  end

  always_comb begin
    ctrl = '0;
    case (state_q)
      TRIG_LOAD_X:  ctrl.load = 1'b1;
      TRIG_RUN_X:   ctrl.iterate = 1'b1;
      TRIG_LOAD_Y: begin
        ctrl.load    = 1'b1;
        ctrl.store_x = 1'b1;
      end
      TRIG_RUN_Y:   ctrl.iterate = 1'b1;
      TRIG_STORE_Y: ctrl.store_y = 1'b1;
      TRIG_IDLE:    ctrl.ready = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRIG_LOAD_X;
    end else begin
      state_q <= state_d;
    end
  end

  assign angle = (state_q == TRIG_LOAD_Y) ? cfg_i.angle_y : cfg_i.angle_x;
  assign dx    = y_q >>> step_q;
  assign dy    = x_q >>> step_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      x_q    <= XY_W'(CORDIC_GAIN);
      y_q    <= '0;
      z_q    <= Z_W'({1'b0, angle[ANGLE_W-3:0]});
      quad_q <= angle[ANGLE_W-1:ANGLE_W-2];
      step_q <= '0;
    end else if (ctrl.iterate) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_lut(step_q);
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_lut(step_q);
      end
      step_q <= step_q + 1'b1;
    end
    if (ctrl.store_x) begin
      {trig_q.cos_x, trig_q.sin_x} <= trig_fold(quad_q, x_q, y_q);
    end
    if (ctrl.store_y) begin
      {trig_q.cos_y, trig_q.sin_y} <= trig_fold(quad_q, x_q, y_q);
    end
  end

  assign trig_o  = trig_q;
  assign ready_o = ctrl.ready;

endmodule

// ===== hdl/ppp_queue.sv =====
// Small FIFO between the front end and the projection pipeline.
module ppp_queue #(
  parameter int DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppp_pkg::point_t data_i,
  output logic            full_o,
  output logic            pop_o,
  output ppp_pkg::point_t data_o
);
  import ppp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  point_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             empty;

  // the pipeline behind never stalls: pop whenever something is held
  assign empty  = (count_q == '0);
  assign full_o = (count_q == CNT_W'(DEPTH));
  assign pop_o  = ~empty;
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_o) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_o) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_o) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/ppp_back.sv =====
// Projection pipeline: two rotations, depth, scaling, pipelined divide, saturation.
module ppp_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  input  ppp_pkg::point_t                    point_i,
  input  ppp_pkg::trig_t                     trig_i,
  input  ppp_pkg::cfg_t                      cfg_i,
  output logic                               done_o,
  output logic signed [ppp_pkg::OUT_W-1:0]   screen_x_o,
  output logic signed [ppp_pkg::OUT_W-1:0]   screen_y_o,
  output logic                               behind_viewer_o
);
  import ppp_pkg::*;

  localparam int LANES = 2;
  localparam logic signed [PROD2_W-1:0] RND = PROD2_W'(8192);

  // stage 1: first rotation products
  logic                        s1_vld_q;
  logic signed [PROD1_W-1:0]   p_cy_q, p_sz_q, p_sy_q, p_cz_q;
  logic signed [COORD_W-1:0]   s1_x_q;
  // stage 2: rotated about x
  logic                        s2_vld_q;
  logic signed [ROT_W-1:0]     yr_q, zx_q;
  logic signed [COORD_W-1:0]   s2_x_q;
  logic signed [PROD2_W-1:0]   sum_y, sum_z;
  // stage 3: second rotation products
  logic                        s3_vld_q;
  logic signed [PROD2_W-1:0]   q_cx_q, q_sz_q, q_cz_q, q_sx_q;
  logic signed [ROT_W-1:0]     s3_yr_q;
  // stage 4: rotated about y
  logic                        s4_vld_q;
  logic signed [ROT_W-1:0]     xr_q, zr_q, s4_yr_q;
  logic signed [PROD2_W-1:0]   sum_x, sum_zr;
  // stage 5: depth and scaled numerators
  logic                        s5_vld_q;
  logic signed [DEPTH_W-1:0]   depth_q;
  logic signed [SPROD_W-1:0]   sprod_q [LANES];
  // stage 6 and divider
  logic                        behind;
  logic [DIV_W-1:0]            dvs;
  logic [SPROD_W-1:0]          mag  [LANES];
  logic [NUM_W-1:0]            num  [LANES];
  logic                        dv_vld_q    [QBITS+1];
  logic                        dv_behind_q [QBITS+1];
  logic [DIV_W-1:0]            dv_d_q      [QBITS+1];
  logic [DIV_W-1:0]            rem_q [LANES][QBITS+1];
  logic [QBITS-1:0]            nlo_q [LANES][QBITS+1];
  logic [QBITS-1:0]            quo_q [LANES][QBITS+1];
  logic                        neg_q [LANES][QBITS+1];
  logic                        ovf_q [LANES][QBITS+1];
  logic [DIV_W:0]              trial [LANES][QBITS];
  logic                        fits  [LANES][QBITS];
  // output
  logic signed [OUT_W-1:0]     res [LANES];
  logic                        done_q, behind_q;
  logic signed [OUT_W-1:0]     sx_q, sy_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      for (int k = 0; k <= QBITS; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      dv_vld_q[0] <= s5_vld_q;
      for (int k = 0; k < QBITS; k++) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
      done_q   <= dv_vld_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    p_cy_q <= trig_i.cos_x * point_i.y;
    p_sz_q <= trig_i.sin_x * point_i.z;
    p_sy_q <= trig_i.sin_x * point_i.y;
    p_cz_q <= trig_i.cos_x * point_i.z;
    s1_x_q <= point_i.x;
  end

  assign sum_y = PROD2_W'(p_cy_q) - PROD2_W'(p_sz_q) + RND;
  assign sum_z = PROD2_W'(p_sy_q) + PROD2_W'(p_cz_q) + RND;

  always_ff @(posedge clk_i) begin
    yr_q   <= ROT_W'(sum_y >>> 14);
    zx_q   <= ROT_W'(sum_z >>> 14);
    s2_x_q <= s1_x_q;
  end

  always_ff @(posedge clk_i) begin
    q_cx_q  <= trig_i.cos_y * s2_x_q;
    q_sz_q  <= trig_i.sin_y * zx_q;
    q_cz_q  <= trig_i.cos_y * zx_q;
    q_sx_q  <= trig_i.sin_y * s2_x_q;
    s3_yr_q <= yr_q;
  end

  assign sum_x  = q_cx_q + q_sz_q + RND;
  assign sum_zr = q_cz_q - q_sx_q + RND;

  always_ff @(posedge clk_i) begin
    xr_q    <= ROT_W'(sum_x >>> 14);
    zr_q    <= ROT_W'(sum_zr >>> 14);
    s4_yr_q <= s3_yr_q;
  end

  always_ff @(posedge clk_i) begin
    depth_q    <= DEPTH_W'(zr_q) + $signed(DEPTH_W'(cfg_i.distance));
    sprod_q[0] <= xr_q * $signed({1'b0, cfg_i.scale});
    sprod_q[1] <= s4_yr_q * $signed({1'b0, cfg_i.scale});
  end

  // rounded divide: n = |num| * 16 + d/2, quotient bits from the top
  assign behind = depth_q[DEPTH_W-1] | (depth_q == '0);
  assign dvs    = depth_q[DIV_W-1:0];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = sprod_q[l][SPROD_W-1] ? SPROD_W'(-sprod_q[l]) : SPROD_W'(sprod_q[l]);
      num[l] = NUM_W'({mag[l][SPROD_W-2:0], 4'b0000}) + NUM_W'(dvs >> 1);
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int k = 0; k < QBITS; k++) begin
        trial[l][k] = {rem_q[l][k], nlo_q[l][k][QBITS-1]};
        fits[l][k]  = (trial[l][k] >= {1'b0, dv_d_q[k]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_behind_q[0] <= behind;
    dv_d_q[0]      <= dvs;
    for (int k = 0; k < QBITS; k++) begin
      dv_behind_q[k+1] <= dv_behind_q[k];
      dv_d_q[k+1]      <= dv_d_q[k];
    end
    for (int l = 0; l < LANES; l++) begin
      rem_q[l][0] <= DIV_W'(num[l][NUM_W-1:QBITS]);
      nlo_q[l][0] <= num[l][QBITS-1:0];
      quo_q[l][0] <= '0;
      neg_q[l][0] <= sprod_q[l][SPROD_W-1];
      ovf_q[l][0] <= (DIV_W'(num[l][NUM_W-1:QBITS]) >= dvs);
      for (int k = 0; k < QBITS; k++) begin
        rem_q[l][k+1] <= fits[l][k] ? DIV_W'(trial[l][k] - {1'b0, dv_d_q[k]})
                                    : DIV_W'(trial[l][k]);
        nlo_q[l][k+1] <= {nlo_q[l][k][QBITS-2:0], 1'b0};
        quo_q[l][k+1] <= {quo_q[l][k][QBITS-2:0], fits[l][k]};
        neg_q[l][k+1] <= neg_q[l][k];
        ovf_q[l][k+1] <= ovf_q[l][k];
      end
    end
  end

  // sign, center offset, saturate
  always_comb begin
    logic signed [TOT_W-1:0] val;
    logic signed [TOT_W-1:0] tot;
    logic [PIX_W-1:0]        ctr;
    for (int l = 0; l < LANES; l++) begin
      ctr = (l == 0) ? cfg_i.center_x : cfg_i.center_y;
      val = neg_q[l][QBITS] ? -$signed(TOT_W'(quo_q[l][QBITS]))
                            : $signed(TOT_W'(quo_q[l][QBITS]));
      tot = val + $signed(TOT_W'({ctr, 4'b0000}));
      if (ovf_q[l][QBITS]) begin
        res[l] = neg_q[l][QBITS] ? OUT_W'(-32768) : OUT_W'(32767);
      end else if (tot > 32767) begin
        res[l] = OUT_W'(32767);
      end else if (tot < -32768) begin
        res[l] = OUT_W'(-32768);
      end else begin
        res[l] = OUT_W'(tot);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    behind_q <= dv_behind_q[QBITS];
    sx_q     <= dv_behind_q[QBITS] ? '0 : res[0];
    sy_q     <= dv_behind_q[QBITS] ? '0 : res[1];
  end

  assign done_o          = done_q;
  assign screen_x_o      = sx_q;
  assign screen_y_o      = sy_q;
  assign behind_viewer_o = behind_q;

`ifndef SYNTHESIS
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && behind_viewer_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("behind-viewer result carries nonzero coordinates");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(dv_vld_q[QBITS]))
    else $error("result strobe out of step with the divider pipeline");

  a_rem_range_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[0] && !dv_behind_q[0] && !ovf_q[0][0]) |-> (rem_q[0][0] < dv_d_q[0]))
    else $error("x divider starts with remainder not below divisor");

  a_rem_range_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[0] && !dv_behind_q[0] && !ovf_q[1][0]) |-> (rem_q[1][0] < dv_d_q[0]))
    else $error("y divider starts with remainder not below divisor");
`endif

endmodule

// ===== hdl/perspective_point_projector.sv =====
// Top level of the perspective point projector.
//
//  channel   direction  handshake                 payload
//  command   in         start & !busy             point_x_i, point_y_i, point_z_i
//  result    out        done_o, one cycle         screen_x_o, screen_y_o, behind_viewer_o
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One point is accepted per cycle while busy is low; the point then passes the input
// register, the queue, the two rotations, the depth and scaling stage and the 18-stage
// restoring divider before done_o strobes. After reset, and after each angle write, busy
// stays high while the shared CORDIC unit works out both sine/cosine pairs.
// Results cannot be held off; the pipeline behind the input queue never stalls.
module perspective_point_projector #(
  parameter int QUEUE_DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [ppp_pkg::COORD_W-1:0] point_z_i,
  input  logic                               cfg_we_i,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ppp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                               done_o,
  output logic signed [ppp_pkg::OUT_W-1:0]   screen_x_o,
  output logic signed [ppp_pkg::OUT_W-1:0]   screen_y_o,
  output logic                               behind_viewer_o
);
  import ppp_pkg::*;

  cfg_t   cfg;
  trig_t  trig;
  point_t front_point, queue_point;
  logic   trig_req, trig_ready, push, pop, queue_full;

  ppp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .trig_ready_i (trig_ready),
    .queue_full_i (queue_full),
    .cfg_o        (cfg),
    .trig_req_o   (trig_req),
    .push_o       (push),
    .point_o      (front_point)
  );

  ppp_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .req_i   (trig_req),
    .trig_o  (trig),
    .ready_o (trig_ready)
  );

  ppp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_point),
    .full_o (queue_full),
    .pop_o  (pop),
    .data_o (queue_point)
  );

  ppp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vld_i           (pop),
    .point_i         (queue_point),
    .trig_i          (trig),
    .cfg_i           (cfg),
    .done_o          (done_o),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .behind_viewer_o (behind_viewer_o)
  );

endmodule
